// ===== design/mcmmc3_pkg.sv =====
// types, codes and reset tables shared by the multicart mmc3 bank mapper
package mcmmc3_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_PRG   = 2'd2,
        ACT_CHR   = 2'd3
    } action_t;

    localparam logic [1:0] KIND_ROM  = 2'd0;
    localparam logic [1:0] KIND_RAM  = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    localparam logic [1:0] CFG_DIP      = 2'd0;
    localparam logic [1:0] CFG_SUBTYPE  = 2'd1;
    localparam logic [1:0] CFG_CHR_RAM  = 2'd2;
    localparam logic [1:0] CFG_CHR_ROM  = 2'd3;
    localparam int unsigned CFG_DATA_W  = 3;

    localparam logic [1:0] SUBTYPE_BOOT20 = 2'd1;
    localparam logic [1:0] SUBTYPE_SWAP   = 2'd2;

    // mmc3 register decode on {a[14:13], a[0]}
    localparam logic [2:0] MMC3_BANK_SEL  = 3'b000;
    localparam logic [2:0] MMC3_BANK_DATA = 3'b001;
    localparam logic [2:0] MMC3_MIRROR    = 3'b010;
    localparam logic [2:0] MMC3_RAM_CTRL  = 3'b011;
    localparam logic [2:0] MMC3_IRQ_LATCH = 3'b100;
    localparam logic [2:0] MMC3_IRQ_RELD  = 3'b101;
    localparam logic [2:0] MMC3_IRQ_OFF   = 3'b110;
    localparam logic [2:0] MMC3_IRQ_ON    = 3'b111;

    localparam logic [7:0] SEL_SWAP_A = 8'h46;
    localparam logic [7:0] SEL_SWAP_B = 8'h47;
    localparam logic [7:0] OUTER1_BOOT = 8'h20;
    localparam logic [7:0] RAM_CTRL_RESET = 8'h80;

    localparam logic [11:0][7:0] BANK_RESET = {
        8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'h01, 8'h00,
        8'h07, 8'h06, 8'h05, 8'h04, 8'h02, 8'h00
    };

    // chr bank register for each 1 KiB slot in extended mmc3 mode
    localparam logic [7:0][3:0] CHR_PICK = {
        4'd5, 4'd4, 4'd3, 4'd2, 4'd11, 4'd1, 4'd10, 4'd0
    };

    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] address;
        action_t     action;
    } item_t;

    typedef struct packed {
        logic [3:0][7:0]  outer;
        logic [11:0][7:0] bank;
        logic [7:0]       bank_select;
        logic [7:0]       mirror;
        logic [7:0]       ram_control;
        logic [1:0]       cnrom;
        logic [2:0]       dip;
        logic [1:0]       subtype;
        logic             chr_ram;
        logic             chr_rom;
    } map_state_t;

    typedef struct packed {
        logic [1:0] mirroring;
        logic       irq_line;
        logic       wram_write;
    } post_t;

    typedef struct packed {
        logic [12:0] mapped_bank;
        logic [1:0]  memory_kind;
    } lookup_t;

endpackage

// ===== design/mcmmc3_regs.sv =====
// mapper register file: cpu write decode, irq counter and configuration
module mcmmc3_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                fire,
    input  mcmmc3_pkg::item_t                   item,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_addr,
    input  logic [mcmmc3_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output mcmmc3_pkg::map_state_t              st,
    output mcmmc3_pkg::post_t                   post
);

    mcmmc3_pkg::map_state_t st_reg, st_next;
    logic [7:0] irq_cnt_reg, irq_cnt_next;
    logic [7:0] irq_reload_reg, irq_reload_next;
    logic       irq_en_reg, irq_en_next;
    logic       irq_flag_reg, irq_flag_next;
    logic       irq_pend_reg, irq_pend_next;

    logic       wram_wr;
    logic       wram_ext;
    logic [7:0] abits;
    logic [7:0] sel_v;
    logic [3:0] bidx;
    logic [3:0] hi;

    assign wram_ext = st_reg.ram_control[5];
    assign abits    = item.address[11:4];
    assign hi       = item.address[15:12];

    always_comb begin
        st_next         = st_reg;
        irq_cnt_next    = irq_cnt_reg;
        irq_reload_next = irq_reload_reg;
        irq_en_next     = irq_en_reg;
        irq_flag_next   = irq_flag_reg;
        irq_pend_next   = irq_pend_reg;
        wram_wr         = 1'b0;
        sel_v           = item.data;
        bidx            = st_reg.bank_select[3:0] & (st_reg.outer[3][1] ? 4'hF : 4'h7);

        if (fire) begin
            case (item.action)
                mcmmc3_pkg::ACT_WRITE: begin
                    if (hi == 4'h5) begin
                        if ((!wram_ext || st_reg.ram_control[6]) && abits[st_reg.dip]) begin
                            st_next.outer[item.address[1:0]] = item.data;
                            if (item.address[1:0] == 2'd2) begin
                                st_next.cnrom = 2'd0;
                            end
                        end else if (wram_ext) begin
                            wram_wr = 1'b1;
                        end
                    end else if (item.address[15]) begin
                        // with outer[0][6] set, the cnrom latch snoops each write outside $a000-$bfff
                        if (hi != 4'hA && hi != 4'hB && st_reg.outer[0][6]) begin
                            st_next.cnrom = (st_reg.outer[0][2:0] == 3'd3) ? 2'd0
                                                                          : item.data[1:0];
                        end
                        case ({item.address[14:13], item.address[0]})
                            mcmmc3_pkg::MMC3_BANK_SEL: begin
                                if (st_reg.subtype == mcmmc3_pkg::SUBTYPE_SWAP) begin
                                    if (item.data == mcmmc3_pkg::SEL_SWAP_A) begin
                                        sel_v = mcmmc3_pkg::SEL_SWAP_B;
                                    end else if (item.data == mcmmc3_pkg::SEL_SWAP_B) begin
                                        sel_v = mcmmc3_pkg::SEL_SWAP_A;
                                    end
                                end
                                st_next.bank_select = sel_v;
                            end
                            mcmmc3_pkg::MMC3_BANK_DATA: begin
                                if (bidx < 4'd12) begin
                                    st_next.bank[bidx] = item.data;
                                end
                            end
                            mcmmc3_pkg::MMC3_MIRROR: st_next.mirror = item.data;
                            mcmmc3_pkg::MMC3_RAM_CTRL: begin
                                st_next.ram_control = item.data[5] ? item.data
                                                                   : (item.data & 8'hC0);
                            end
                            mcmmc3_pkg::MMC3_IRQ_LATCH: irq_reload_next = item.data;
                            mcmmc3_pkg::MMC3_IRQ_RELD:  irq_flag_next   = 1'b1;
                            mcmmc3_pkg::MMC3_IRQ_OFF: begin
                                irq_en_next   = 1'b0;
                                irq_pend_next = 1'b0;
                            end
                            default: irq_en_next = 1'b1;
                        endcase
                    end
                end
                mcmmc3_pkg::ACT_TICK: begin
                    if (irq_cnt_reg == 8'd0 || irq_flag_reg) begin
                        irq_cnt_next = irq_reload_reg;
                    end else begin
                        irq_cnt_next = irq_cnt_reg - 8'd1;
                    end
                    if (irq_cnt_next == 8'd0 && irq_en_reg) begin
                        irq_pend_next = 1'b1;
                    end
                    irq_flag_next = 1'b0;
                end
                default: ;
            endcase
        end

        if (cfg_we) begin
            case (cfg_addr)
                mcmmc3_pkg::CFG_DIP: st_next.dip = cfg_wdata[2:0];
                mcmmc3_pkg::CFG_SUBTYPE: begin
                    st_next.subtype = cfg_wdata[1:0];
                    if (cfg_wdata[1:0] == mcmmc3_pkg::SUBTYPE_BOOT20) begin
                        st_next.outer[1] = mcmmc3_pkg::OUTER1_BOOT;
                    end
                end
                mcmmc3_pkg::CFG_CHR_RAM: st_next.chr_ram = cfg_wdata[0];
                default: st_next.chr_rom = cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.outer       <= '0;
            st_reg.bank        <= mcmmc3_pkg::BANK_RESET;
            st_reg.bank_select <= 8'd0;
            st_reg.mirror      <= 8'd0;
            st_reg.ram_control <= mcmmc3_pkg::RAM_CTRL_RESET;
            st_reg.cnrom       <= 2'd0;
            st_reg.dip         <= 3'd0;
            st_reg.subtype     <= 2'd0;
            st_reg.chr_ram     <= 1'b0;
            st_reg.chr_rom     <= 1'b1;
            irq_cnt_reg        <= 8'd0;
            irq_reload_reg     <= 8'd0;
            irq_en_reg         <= 1'b0;
            irq_flag_reg       <= 1'b0;
            irq_pend_reg       <= 1'b0;
        end else begin
            st_reg         <= st_next;
            irq_cnt_reg    <= irq_cnt_next;
            irq_reload_reg <= irq_reload_next;
            irq_en_reg     <= irq_en_next;
            irq_flag_reg   <= irq_flag_next;
            irq_pend_reg   <= irq_pend_next;
        end
    end

    assign st = st_reg;

    // result status reflects the state after this item
    assign post.mirroring  = {st_next.mirror[1] & st_next.ram_control[5], st_next.mirror[0]};
    assign post.irq_line   = irq_pend_next;
    assign post.wram_write = wram_wr;

endmodule

// ===== design/mcmmc3_map.sv =====
// prg and chr bank lookup from the current mapper state
module mcmmc3_map (
    input  mcmmc3_pkg::item_t      item,
    input  mcmmc3_pkg::map_state_t st,
    output mcmmc3_pkg::lookup_t    res
);

    logic [15:0] a;
    logic [7:0]  r0;
    logic        wram_ext;
    logic        mmc3_ext;
    logic [2:0]  mode;
    logic [1:0]  pslot;
    logic [1:0]  pslot_adj;
    logic [11:0] base;
    logic [12:0] pb;
    logic [12:0] pmask;
    logic [7:0]  pfix;
    logic [2:0]  cslot;
    logic [2:0]  l;
    logic [3:0]  ridx;
    logic [7:0]  bank_rd;
    logic [7:0]  cm;
    logic [1:0]  cn_m;
    logic [7:0]  cv8;
    logic [10:0] cv;
    logic        cram;

    assign a        = item.address;
    assign r0       = st.outer[0];
    assign wram_ext = st.ram_control[5];
    assign mmc3_ext = st.outer[3][1];
    assign mode     = r0[2:0];
    assign pslot    = a[14:13];
    assign cslot    = a[12:10];
    assign l        = cslot ^ {st.bank_select[7], 2'b00};
    assign base     = {st.outer[2][5], st.outer[2][7:6], r0[7], r0[3], st.outer[1][6:0]};
    assign pb       = {base, 1'b0};
    assign pmask    = 13'h3F >> mode[1:0];
    assign cm       = r0[4] ? 8'h7F : 8'hFF;

    always_comb begin
        pslot_adj = pslot;
        if (st.bank_select[6] && !pslot[0]) begin
            pslot_adj = pslot ^ 2'd2;
        end
    end

    // one read port into the bank registers, steered by the lookup kind
    always_comb begin
        if (item.action == mcmmc3_pkg::ACT_PRG) begin
            ridx = 4'd6 + {2'b00, pslot_adj};
        end else if (mmc3_ext) begin
            ridx = mcmmc3_pkg::CHR_PICK[l];
        end else if (!l[2]) begin
            ridx = {3'b000, l[1]};
        end else begin
            ridx = {1'b0, l} - 4'd2;
        end
    end

    assign bank_rd = (ridx < 4'd12) ? st.bank[ridx] : 8'd0;

    always_comb begin
        case (pslot_adj)
            2'd0:    pfix = bank_rd;
            2'd1:    pfix = bank_rd;
            2'd2:    pfix = 8'hFE;
            default: pfix = 8'hFF;
        endcase
    end

    always_comb begin
        cn_m = 2'd0;
        cv8  = 8'd0;
        if ((st.outer[3] & 8'h46) != 8'd0) begin
            cn_m = r0[4] ? 2'd1 : 2'd3;
        end
        if (r0[6]) begin
            cv8 = st.outer[2] | {6'd0, st.cnrom & cn_m};
            cv  = {cv8, cslot};
        end else if (mmc3_ext) begin
            cv = {3'd0, bank_rd} | {st.outer[2], 3'd0};
        end else if (!l[2]) begin
            cv8 = (bank_rd & cm);
            cv8 = l[0] ? (cv8 | 8'h01) : (cv8 & 8'hFE);
            cv  = {3'd0, cv8} | {st.outer[2], 3'd0};
        end else begin
            cv = {3'd0, bank_rd & cm} | {st.outer[2], 3'd0};
        end
        cram = !st.chr_rom || (st.chr_ram && r0[5]);
        if (wram_ext) begin
            cram = (st.ram_control[2] && cv < 11'd8) || !st.chr_rom;
        end
    end

    always_comb begin
        res.mapped_bank = 13'd0;
        res.memory_kind = mcmmc3_pkg::KIND_NONE;
        case (item.action)
            mcmmc3_pkg::ACT_PRG: begin
                if (a[15]) begin
                    res.memory_kind = mcmmc3_pkg::KIND_ROM;
                    if (mode[2]) begin
                        res.mapped_bank = {base[11:1], pslot};
                    end else if (mode == 3'd3) begin
                        res.mapped_bank = {base, pslot[0]};
                    end else if (mmc3_ext) begin
                        res.mapped_bank = {5'd0, bank_rd} | pb;
                    end else begin
                        res.mapped_bank = ({5'd0, pfix} & pmask) | (pb & ~pmask);
                    end
                end else if (a[14] && !a[13]) begin
                    // $4000-$5fff only backed by extended wram
                    if (wram_ext) begin
                        res.memory_kind = mcmmc3_pkg::KIND_RAM;
                        res.mapped_bank = {11'd0, st.ram_control[1:0]} + 13'd1;
                    end
                end else if (a[14]) begin
                    if (st.ram_control[7] || wram_ext) begin
                        res.memory_kind = mcmmc3_pkg::KIND_RAM;
                        res.mapped_bank = wram_ext ? {11'd0, st.ram_control[1:0]} : 13'd0;
                    end
                end
            end
            mcmmc3_pkg::ACT_CHR: begin
                if (a[15:13] == 3'd0) begin
                    res.memory_kind = cram ? mcmmc3_pkg::KIND_RAM : mcmmc3_pkg::KIND_ROM;
                    res.mapped_bank = {2'd0, cv};
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== design/multicart_mmc3_bank_mapper.sv =====
// top level of the multicart mmc3 bank mapper: handshake, pipeline registers
// usage:
//   s_ channel carries one item: a cpu write, a scanline tick, a prg lookup
//   or a chr lookup (kind in s_tuser). every item returns exactly one result
//   on the m_ channel: bank number and status in m_tdata, memory kind in
//   m_tuser. writes and ticks return kind unmapped with bank 0, plus the
//   mirroring and irq line as they stand after the item.
//   cfg_we/cfg_addr/cfg_wdata set dip switch, board subtype and the chr
//   memory straps; write them only while no item is in flight.
// timing:
//   an item is registered in the input register on accept, decoded and applied
//   from there, and its result is loaded into the output register when the
//   output stage can advance, which raises m_tvalid. one item per cycle is
//   sustained while m_tready stays high; the bound is the single decode stage.
// reset and stall:
//   aresetn (synchronous, low) restores the power-on mapper state and empties
//   both stages. while m_tready is low the result holds, one more item can
//   wait in the input register, and then s_tready drops.
module multicart_mmc3_bank_mapper (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,  // address[15:0], data[23:16]
    input  logic [1:0]                          s_tuser,  // action[1:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mapped_bank[12:0], mirroring[14:13], irq_line[15], wram_write[16], zero[23:17]
    output logic [23:0]                         m_tdata,
    output logic [1:0]                          m_tuser,  // memory_kind[1:0]
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_addr,
    input  logic [mcmmc3_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    mcmmc3_pkg::item_t      in_item_reg;
    logic                   in_valid_reg, in_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [23:0]            out_data_reg;
    logic [1:0]             out_kind_reg;
    logic                   advance;
    logic                   fire;
    logic                   take;
    mcmmc3_pkg::map_state_t st;
    mcmmc3_pkg::post_t      post;
    mcmmc3_pkg::lookup_t    look;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = advance || !in_valid_reg;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_item_reg.action  <= mcmmc3_pkg::action_t'(s_tuser);
            in_item_reg.address <= s_tdata[15:0];
            in_item_reg.data    <= s_tdata[23:16];
        end
        if (fire) begin
            out_data_reg <= {7'd0, post.wram_write, post.irq_line, post.mirroring,
                             look.mapped_bank};
            out_kind_reg <= look.memory_kind;
        end
    end

    mcmmc3_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (in_item_reg),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .st        (st),
        .post      (post)
    );

    mcmmc3_map u_map (
        .item (in_item_reg),
        .st   (st),
        .res  (look)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

// ===== design/mcmmc3_checker.sv =====
// port-level checks for the multicart mmc3 bank mapper
module mcmmc3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a held result must not change under backpressure
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // with the output stage empty the input side can always take an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("memory kind out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == 2'd2 |-> m_tdata[12:0] == 13'd0)
        else $error("unmapped result carries a bank");

    // a wram fall-through is a write, never a lookup
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[16] |-> m_tuser == 2'd2 && m_tdata[12:0] == 13'd0)
        else $error("wram write flagged on a lookup");

endmodule

bind multicart_mmc3_bank_mapper mcmmc3_checker u_mcmmc3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the multicart mmc3 bank mapper: directed and random items
module tb_top;
    import mcmmc3_pkg::*;

    typedef struct packed {
        logic [12:0] bank;
        logic [1:0]  kind;
        logic [1:0]  mirroring;
        logic        irq;
        logic        wram_wr;
    } mapping_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // address[15:0], data[23:16]
    logic [1:0]  s_tuser;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready;
    // mapped_bank[12:0], mirroring[14:13], irq_line[15], wram_write[16], zero[23:17]
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;   // memory_kind[1:0]
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // mapper state as the predictor sees it, power-on values
    logic [7:0] outer_r [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
    logic [7:0] bank_r [12] = '{8'h00, 8'h02, 8'h04, 8'h05, 8'h06, 8'h07,
                                8'h00, 8'h01, 8'hFE, 8'hFF, 8'hFF, 8'hFF};
    logic [7:0] sel_r       = 8'h00;
    logic [7:0] mirror_r    = 8'h00;
    logic [7:0] ramctl_r    = RAM_CTRL_RESET;
    logic [7:0] irq_cnt     = 8'h00;
    logic [7:0] irq_rld_val = 8'h00;
    logic       irq_on      = 1'b0;
    logic       irq_rld_flag = 1'b0;
    logic       irq_pend    = 1'b0;
    logic [1:0] cnrom_r     = 2'd0;
    logic [2:0] dip_cfg     = 3'd0;
    logic [1:0] subtype_cfg = 2'd0;
    logic       chr_ram_cfg = 1'b0;
    logic       chr_rom_cfg = 1'b1;

    mapping_t    expected_maps [$];
    int          fail_count = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;

    multicart_mmc3_bank_mapper DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // applies one item to the mapper state and returns what the block must answer
    function automatic mapping_t map_item(input action_t act, input logic [15:0] a,
                                          input logic [7:0] d);
        mapping_t    r;
        logic [7:0]  v, r0, cm;
        logic [11:0] base;
        logic [12:0] pb, mask, outer, cv;
        logic [15:0] sel_bit;
        logic [2:0]  mode, l, slot3;
        logic [1:0]  slot, m;
        logic [3:0]  idx;
        logic        chr_ram;
        r = '0;
        r.kind = KIND_NONE;
        r0 = outer_r[0];
        case (act)
            ACT_WRITE: begin
                if (a[15:12] == 4'h5) begin
                    sel_bit = 16'h0010 << dip_cfg;
                    if ((!ramctl_r[5] || ramctl_r[6]) && (a & sel_bit) != 16'h0) begin
                        outer_r[a[1:0]] = d;
                        if (a[1:0] == 2'd2) cnrom_r = 2'd0;
                    end else if (ramctl_r[5]) begin
                        r.wram_wr = 1'b1;
                    end
                end else if (a[15]) begin
                    if (a[15:12] != 4'hA && a[15:12] != 4'hB && r0[6])
                        cnrom_r = (r0[2:0] == 3'd3) ? 2'd0 : d[1:0];
                    v = d;
                    case ({a[14:13], a[0]})
                        MMC3_BANK_SEL: begin
                            if (subtype_cfg == SUBTYPE_SWAP && v == SEL_SWAP_A) v = SEL_SWAP_B;
                            else if (subtype_cfg == SUBTYPE_SWAP && v == SEL_SWAP_B) v = SEL_SWAP_A;
                            sel_r = v;
                        end
                        MMC3_BANK_DATA: begin
                            idx = sel_r[3:0] & (outer_r[3][1] ? 4'hF : 4'h7);
                            if (idx < 4'd12) bank_r[idx] = d;
                        end
                        MMC3_MIRROR:    mirror_r = d;
                        MMC3_RAM_CTRL:  ramctl_r = d[5] ? d : (d & 8'hC0);
                        MMC3_IRQ_LATCH: irq_rld_val = d;
                        MMC3_IRQ_RELD:  irq_rld_flag = 1'b1;
                        MMC3_IRQ_OFF: begin
                            irq_on = 1'b0;
                            irq_pend = 1'b0;
                        end
                        default:        irq_on = 1'b1;
                    endcase
                end
            end
            ACT_TICK: begin
                if (irq_cnt == 8'd0 || irq_rld_flag) irq_cnt = irq_rld_val;
                else irq_cnt = irq_cnt - 8'd1;
                if (irq_cnt == 8'd0 && irq_on) irq_pend = 1'b1;
                irq_rld_flag = 1'b0;
            end
            ACT_PRG: begin
                mode = r0[2:0];
                slot = a[14:13];
                base = {outer_r[2][5], outer_r[2][7:6], r0[7], r0[3], outer_r[1][6:0]};
                if (a < 16'h4000) begin
                    r.kind = KIND_NONE;
                end else if (a < 16'h6000) begin
                    // extended wram window
                    if (ramctl_r[5]) begin
                        r.kind = KIND_RAM;
                        r.bank = {11'd0, ramctl_r[1:0]} + 13'd1;
                    end
                end else if (a < 16'h8000) begin
                    if (ramctl_r[7] || ramctl_r[5]) begin
                        r.kind = KIND_RAM;
                        r.bank = ramctl_r[5] ? {11'd0, ramctl_r[1:0]} : 13'd0;
                    end
                end else begin
                    r.kind = KIND_ROM;
                    if (mode >= 3'd4) begin
                        r.bank = {base[11:1], slot};
                    end else if (mode == 3'd3) begin
                        r.bank = {base, slot[0]};
                    end else begin
                        mask = 13'h3F >> mode;
                        pb = {base, 1'b0};
                        if (sel_r[6] && !slot[0]) slot = slot ^ 2'd2;
                        if (outer_r[3][1]) begin
                            r.bank = {5'd0, bank_r[6 + slot]} | pb;
                        end else begin
                            case (slot)
                                2'd0:    v = bank_r[6];
                                2'd1:    v = bank_r[7];
                                2'd2:    v = 8'hFE;
                                default: v = 8'hFF;
                            endcase
                            r.bank = ({5'd0, v} & mask) | (pb & ~mask);
                        end
                    end
                end
            end
            ACT_CHR: begin
                if (a < 16'h2000) begin
                    slot3 = a[12:10];
                    if (r0[6]) begin
                        // cnrom style: outer bank plus latch bits
                        m = ((outer_r[3] & 8'h46) != 8'h0) ? (r0[4] ? 2'd1 : 2'd3) : 2'd0;
                        cv = {2'd0, outer_r[2] | {6'd0, cnrom_r & m}, 3'd0} + {10'd0, slot3};
                    end else begin
                        outer = {2'd0, outer_r[2], 3'd0};
                        cm = r0[4] ? 8'h7F : 8'hFF;
                        l = slot3 ^ (sel_r[7] ? 3'd4 : 3'd0);
                        if (outer_r[3][1]) begin
                            case (l)
                                3'd0:    v = bank_r[0];
                                3'd1:    v = bank_r[10];
                                3'd2:    v = bank_r[1];
                                3'd3:    v = bank_r[11];
                                3'd4:    v = bank_r[2];
                                3'd5:    v = bank_r[3];
                                3'd6:    v = bank_r[4];
                                default: v = bank_r[5];
                            endcase
                            cv = {5'd0, v} | outer;
                        end else if (l < 3'd4) begin
                            v = bank_r[l[1]] & cm;
                            v = l[0] ? (v | 8'h01) : (v & 8'hFE);
                            cv = {5'd0, v} | outer;
                        end else begin
                            cv = {5'd0, bank_r[l - 3'd2] & cm} | outer;
                        end
                    end
                    chr_ram = !chr_rom_cfg || (chr_ram_cfg && r0[5]);
                    if (ramctl_r[5]) chr_ram = (ramctl_r[2] && cv < 13'd8) || !chr_rom_cfg;
                    r.kind = chr_ram ? KIND_RAM : KIND_ROM;
                    r.bank = cv;
                end
            end
        endcase
        r.mirroring = mirror_r[1:0] & (ramctl_r[5] ? 2'b11 : 2'b01);
        r.irq = irq_pend;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [12:0] want,
                               input logic [12:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        mapping_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_maps.size() == 0) begin
                $error("item with no expectation: m_tdata %h, m_tuser %h", m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = expected_maps.pop_front();
                check_field("mapped_bank", want.bank, m_tdata[12:0]);
                check_field("memory_kind", 13'(want.kind), 13'(m_tuser));
                check_field("mirroring", 13'(want.mirroring), 13'(m_tdata[14:13]));
                check_field("irq_line", 13'(want.irq), 13'(m_tdata[15]));
                check_field("wram_write", 13'(want.wram_wr), 13'(m_tdata[16]));
                check_field("tdata padding", 13'd0, 13'(m_tdata[23:17]));
            end
        end
        if (aresetn && s_tvalid && s_tready)
            expected_maps.push_back(map_item(action_t'(s_tuser), s_tdata[15:0], s_tdata[23:16]));
    end

    task automatic issue_item(input action_t act, input logic [15:0] addr, input logic [7:0] dat);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {dat, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_quiet();
        int guard;
        guard = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_maps.size() != 0 && guard < 20000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DIP:     dip_cfg = val;
            CFG_SUBTYPE: begin
                subtype_cfg = val[1:0];
                if (subtype_cfg == SUBTYPE_BOOT20) outer_r[1] = OUTER1_BOOT;
            end
            CFG_CHR_RAM: chr_ram_cfg = val[0];
            default:     chr_rom_cfg = val[0];
        endcase
    endtask

    task automatic test_power_on_state();
        issue_item(ACT_PRG, 16'h0000, 8'h00);  // below the wram window
        issue_item(ACT_PRG, 16'h6000, 8'hFF);
        issue_item(ACT_PRG, 16'hFFFF, 8'h00);
        issue_item(ACT_CHR, 16'h2000, 8'h00);  // nametable space
    endtask

    task automatic test_mmc3_registers();
        issue_item(ACT_WRITE, 16'h8000, 8'hC7);
        issue_item(ACT_WRITE, 16'h8001, 8'h35);
        issue_item(ACT_PRG, 16'h8000, 8'h00);
        issue_item(ACT_WRITE, 16'hA000, 8'h03);
        issue_item(ACT_WRITE, 16'hA001, 8'h24);
        // outer registers locked out, write lands in wram
        issue_item(ACT_WRITE, 16'h5010, 8'h00);
        issue_item(ACT_PRG, 16'h4000, 8'h00);
        issue_item(ACT_CHR, 16'h0000, 8'h00);
        issue_item(ACT_WRITE, 16'hA001, 8'h1F);
        issue_item(ACT_PRG, 16'h6000, 8'h00);
        issue_item(ACT_WRITE, 16'hA001, 8'h80);
    endtask

    task automatic test_outer_registers();
        issue_item(ACT_WRITE, 16'h5000, 8'h07);  // dip bit clear
        issue_item(ACT_WRITE, 16'h5010, 8'h05);  // prg mode 5, banks by base and slot
        issue_item(ACT_PRG, 16'hA000, 8'h00);
        issue_item(ACT_WRITE, 16'h5013, 8'h02);
        issue_item(ACT_WRITE, 16'h8000, 8'h0E);  // select past the last bank register
        issue_item(ACT_WRITE, 16'h8001, 8'h55);
        issue_item(ACT_WRITE, 16'h5010, 8'h43);
        issue_item(ACT_WRITE, 16'h5012, 8'h21);
        issue_item(ACT_WRITE, 16'hC000, 8'h02);
        issue_item(ACT_CHR, 16'h1C00, 8'h00);
    endtask

    task automatic test_irq_counter();
        issue_item(ACT_WRITE, 16'hC001, 8'h00);
        issue_item(ACT_WRITE, 16'hE001, 8'h00);
        issue_item(ACT_TICK, 16'h0000, 8'h00);
        issue_item(ACT_TICK, 16'hFFFF, 8'hFF);
        issue_item(ACT_TICK, 16'h0000, 8'h00);
        issue_item(ACT_WRITE, 16'hE000, 8'h00);
    endtask

    task automatic test_subtype_straps();
        wait_quiet();
        cfg_write(CFG_SUBTYPE, {1'b0, SUBTYPE_SWAP});
        issue_item(ACT_WRITE, 16'h8000, SEL_SWAP_A);
        issue_item(ACT_WRITE, 16'h8001, 8'h12);
        issue_item(ACT_PRG, 16'hE000, 8'h00);
        wait_quiet();
        cfg_write(CFG_SUBTYPE, {1'b0, SUBTYPE_BOOT20});
        issue_item(ACT_PRG, 16'h8000, 8'h00);
    endtask

    task automatic test_random_traffic();
        logic [2:0]  dips [4]  = '{3'd0, 3'd7, 3'd3, 3'd5};
        logic [1:0]  subs [4]  = '{2'd0, 2'd1, 2'd2, 2'd3};
        logic        rams [4]  = '{1'b0, 1'b1, 1'b1, 1'b0};
        logic        roms [4]  = '{1'b1, 1'b0, 1'b1, 1'b0};
        int unsigned pick;
        logic [15:0] addr;
        logic [7:0]  dat;
        logic [2:0]  reg_sel;
        action_t     act;
        for (int ph = 0; ph < 8; ph++) begin
            wait_quiet();
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 76; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 76; end
                default: begin src_idle_pct = 12; sink_stall_pct = 12; end
            endcase
            if (ph < 4) begin
                cfg_write(CFG_DIP, dips[ph]);
                cfg_write(CFG_SUBTYPE, {1'b0, subs[ph]});
                cfg_write(CFG_CHR_RAM, {2'b0, rams[ph]});
                cfg_write(CFG_CHR_ROM, {2'b0, roms[ph]});
            end else begin
                cfg_write(CFG_DIP, 3'($urandom_range(7)));
                cfg_write(CFG_SUBTYPE, 3'($urandom_range(3)));
                cfg_write(CFG_CHR_RAM, 3'($urandom_range(1)));
                cfg_write(CFG_CHR_ROM, 3'($urandom_range(1)));
            end
            repeat (62) begin
                pick = $urandom_range(99);
                dat  = 8'($urandom_range(255));
                if (pick < 14) begin
                    act  = ACT_WRITE;
                    addr = 16'h5000 | 16'($urandom_range(16'h0FFF));
                    if ($urandom_range(9) < 7) addr = addr | (16'h0010 << dip_cfg);
                end else if (pick < 40) begin
                    act = ACT_WRITE;
                    reg_sel = 3'($urandom_range(7));
                    addr = 16'h8000 | 16'($urandom_range(16'h7FFF));
                    addr[14:13] = reg_sel[2:1];
                    addr[0] = reg_sel[0];
                    if (reg_sel == MMC3_BANK_SEL && $urandom_range(3) == 0)
                        dat = $urandom_range(1) ? SEL_SWAP_A : SEL_SWAP_B;
                    else if (reg_sel == MMC3_IRQ_LATCH && $urandom_range(9) < 7)
                        dat = 8'($urandom_range(3));
                end else if (pick < 55) begin
                    act  = ACT_TICK;
                    addr = 16'($urandom_range(16'hFFFF));
                end else if (pick < 76) begin
                    act  = ACT_PRG;
                    addr = ($urandom_range(9) == 0) ? 16'($urandom_range(16'hFFFF))
                                                   : 16'($urandom_range(16'hFFFF, 16'h4000));
                end else if (pick < 95) begin
                    act  = ACT_CHR;
                    addr = ($urandom_range(19) < 17) ? 16'($urandom_range(16'h1FFF))
                                                    : 16'($urandom_range(16'hFFFF));
                end else begin
                    act  = action_t'($urandom_range(3));
                    addr = 16'($urandom_range(16'hFFFF));
                end
                issue_item(act, addr, dat);
            end
        end
        wait_quiet();
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_WRITE;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_DIP;
        cfg_wdata = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        test_power_on_state();
        test_mmc3_registers();
        test_outer_registers();
        test_irq_counter();
        test_subtype_straps();
        test_random_traffic();

        if (expected_maps.size() != 0) begin
            $error("%0d expected items never arrived", expected_maps.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
